// ===== rtl/dfbs_pkg.sv =====
// Shared types and constants for the DFL box and score decoder.
`default_nettype none
package dfbs_pkg;

  localparam int IDX_MAX_W = 5;
  localparam int CLS_MAX_W = 8;
  localparam logic [3:0] EXP_LAST = 4'd8;
  localparam logic [3:0] DIV_LAST = 4'd15;
  localparam logic [3:0] GEO_LAST = 4'd1;
  localparam logic [3:0] BOX_LAST = 4'd3;

  typedef enum logic [3:0] {
    OP_IDLE     = 4'd0,
    OP_LOAD_BIN = 4'd1,
    OP_LOAD_CLS = 4'd2,
    OP_MAX      = 4'd3,
    OP_EXP      = 4'd4,
    OP_DIV      = 4'd5,
    OP_DOT_MUL  = 4'd6,
    OP_DOT_ACC  = 4'd7,
    OP_SAVE     = 4'd8,
    OP_GEO      = 4'd9,
    OP_BOX_OUT  = 4'd10,
    OP_SIG_MUL  = 4'd11,
    OP_SIG_OUT  = 4'd12
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 sig;
    logic [IDX_MAX_W-1:0] idx;
    logic [3:0]           step;
    logic [1:0]           grp;
    logic [CLS_MAX_W-1:0] cls;
    logic                 cls_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/dfbs_ctrl.sv =====
// Sequencer that steps the datapath through group, box and score work.
`default_nettype none
module dfbs_ctrl #(
  parameter int BINS = 16,
  parameter int CLASS_COUNT = 80
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  dfbs_pkg::status_t   status,
  output dfbs_pkg::cmd_t      cmd
);

  localparam int IDX_W = $clog2(BINS);
  localparam int CLS_W = $clog2(CLASS_COUNT + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MAX    = 10'b0000000010,
    S_EXP    = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_DOT    = 10'b0000010000,
    S_SAVE   = 10'b0000100000,
    S_GEO    = 10'b0001000000,
    S_BOX    = 10'b0010000000,
    S_SIGMUL = 10'b0100000000,
    S_SIGOUT = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [3:0] step, step_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] bin_cnt, bin_cnt_next;
  logic [1:0] grp, grp_next;
  logic [CLS_W-1:0] cls, cls_next;
  logic in_cls, in_cls_next;
  logic idx_end, cls_end;

  assign idx_end = (idx == IDX_W'(BINS - 1));
  assign cls_end = (cls == CLS_W'(CLASS_COUNT - 1));

  always_comb begin
    state_next = state;
    step_next = step;
    idx_next = idx;
    bin_cnt_next = bin_cnt;
    grp_next = grp;
    cls_next = cls;
    in_cls_next = in_cls;
    in_ready = (state == S_IDLE);
    cmd.op = dfbs_pkg::OP_IDLE;
    cmd.sig = in_cls;
    cmd.idx = dfbs_pkg::IDX_MAX_W'((state == S_IDLE) ? bin_cnt : idx);
    cmd.step = step;
    cmd.grp = grp;
    cmd.cls = dfbs_pkg::CLS_MAX_W'(cls);
    cmd.cls_last = cls_end;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          step_next = 4'd0;
          if (in_cls) begin
            cmd.op = dfbs_pkg::OP_LOAD_CLS;
            state_next = S_EXP;
          end else begin
            cmd.op = dfbs_pkg::OP_LOAD_BIN;
            if (bin_cnt == IDX_W'(BINS - 1)) begin
              bin_cnt_next = '0;
              idx_next = '0;
              state_next = S_MAX;
            end else begin
              bin_cnt_next = bin_cnt + 1'b1;
            end
          end
        end
      end
      S_MAX: begin
        cmd.op = dfbs_pkg::OP_MAX;
        if (idx_end) begin
          idx_next = '0;
          step_next = 4'd0;
          state_next = S_EXP;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_EXP: begin
        cmd.op = dfbs_pkg::OP_EXP;
        if (step == dfbs_pkg::EXP_LAST) begin
          step_next = 4'd0;
          if (in_cls) begin
            state_next = S_DIV;
          end else if (idx_end) begin
            idx_next = '0;
            state_next = S_DIV;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_DIV: begin
        cmd.op = dfbs_pkg::OP_DIV;
        if (step == dfbs_pkg::DIV_LAST) begin
          step_next = 4'd0;
          idx_next = '0;
          state_next = in_cls ? S_SIGMUL : S_DOT;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_DOT: begin
        if (step[0]) begin
          cmd.op = dfbs_pkg::OP_DOT_ACC;
          step_next = 4'd0;
          if (idx_end) begin
            state_next = S_SAVE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          cmd.op = dfbs_pkg::OP_DOT_MUL;
          step_next = 4'd1;
        end
      end
      S_SAVE: begin
        cmd.op = dfbs_pkg::OP_SAVE;
        grp_next = grp + 2'd1;
        step_next = 4'd0;
        if (grp == 2'd3) begin
          in_cls_next = 1'b1;
          state_next = S_GEO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_GEO: begin
        cmd.op = dfbs_pkg::OP_GEO;
        if (step == dfbs_pkg::GEO_LAST) begin
          step_next = 4'd0;
          state_next = S_BOX;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_BOX: begin
        if (status.out_free) begin
          cmd.op = dfbs_pkg::OP_BOX_OUT;
          if (step == dfbs_pkg::BOX_LAST) begin
            step_next = 4'd0;
            state_next = S_IDLE;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      S_SIGMUL: begin
        cmd.op = dfbs_pkg::OP_SIG_MUL;
        state_next = S_SIGOUT;
      end
      S_SIGOUT: begin
        if (status.out_free) begin
          cmd.op = dfbs_pkg::OP_SIG_OUT;
          state_next = S_IDLE;
          if (cls_end) begin
            cls_next = '0;
            in_cls_next = 1'b0;
          end else begin
            cls_next = cls + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= 4'd0;
      idx <= '0;
      bin_cnt <= '0;
      grp <= 2'd0;
      cls <= '0;
      in_cls <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      idx <= idx_next;
      bin_cnt <= bin_cnt_next;
      grp <= grp_next;
      cls <= cls_next;
      in_cls <= in_cls_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dfbs_dp.sv =====
// Datapath: bin store, shared exp and Q15 multiplier, divider, geometry, output register.
`default_nettype none
module dfbs_dp #(
  parameter int BINS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  dfbs_pkg::cmd_t           cmd,
  output dfbs_pkg::status_t        status,
  input  wire logic signed [7:0]   logit,
  input  wire logic [13:0]         anchor_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [26:0]       value,
  output logic [6:0]               slot,
  output logic                     last
);

  localparam int IDX_W = $clog2(BINS);
  localparam int SUM_W = $clog2(BINS) + 15;
  localparam int EXP_W = $clog2(BINS) + 15;

  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic signed [16:0] fl;
    logic [14:0] rem;
    logic up;
    logic signed [17:0] v;
    p = a * b;
    fl = p[31:15];
    rem = p[14:0];
    up = (rem > 15'd16384) || ((rem == 15'd16384) && fl[0]);
    v = {fl[16], fl} + {17'd0, up};
    if (v > 18'sd32767) begin
      mul_q15 = 16'sd32767;
    end else if (v < -18'sd32768) begin
      mul_q15 = -16'sd32768;
    end else begin
      mul_q15 = v[15:0];
    end
  endfunction

  logic signed [7:0] bin_store [BINS];
  logic [14:0] e_store [BINS];
  logic [EXP_W-1:0] edges [4];

  logic signed [7:0] logit_r, mx;
  logic [13:0] anchor_r;
  logic [7:0] z;
  logic [4:0] q;
  logic signed [15:0] r, r2, r3, r4, t2, t3, t4;
  logic [14:0] e;
  logic [SUM_W-1:0] sum;
  logic [16:0] divisor, rem;
  logic [14:0] quot, m;
  logic sat;
  logic [EXP_W-1:0] dot;
  logic [1:0] sel;
  logic [13:0] grid_pos;
  logic [9:0] gy;
  logic [2:0] sh;
  logic [26:0] cx, cy;
  logic [29:0] sprod;

  logic [IDX_W-1:0] bi;
  logic [14:0] recip;
  logic signed [8:0] zdiff;
  logic [7:0] z_new;
  logic [20:0] qprod;
  logic signed [12:0] rdiff;
  logic signed [18:0] psum;
  logic [14:0] poly, e_new;
  logic signed [15:0] mul_a, mul_b, mq;
  logic [SUM_W-5:0] sum_hi;
  logic [16:0] reduced;
  logic [17:0] trial;
  logic [13:0] grid_pos_new;
  logic [11:0] xg;
  logic [27:0] gprod;
  logic [13:0] gx_full;
  logic [6:0] cols;
  logic [26:0] ev, box_val;
  logic [30:0] sround;

  assign bi = cmd.idx[IDX_W-1:0];
  assign recip = sat ? 15'd32767 : quot;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    if (cmd.sig) begin
      zdiff = logit_r[7] ? (9'sd0 - 9'(logit_r)) : 9'(logit_r);
    end else begin
      zdiff = 9'(mx) - 9'(bin_store[bi]);
    end
    z_new = zdiff[7:0];
    qprod = 21'(z_new) * 21'd5925;
    rdiff = 13'(signed'({1'b0, 12'(q) * 12'd177})) - 13'(signed'({1'b0, z, 4'd0}));
    psum = 19'sd32767 + 19'(r) + 19'(t2) + 19'(t3) + 19'(t4);
    if (psum < 19'sd0) begin
      poly = 15'd0;
    end else if (psum > 19'sd32767) begin
      poly = 15'd32767;
    end else begin
      poly = psum[14:0];
    end
    e_new = (q >= 5'd15) ? 15'd0 : (poly >> q);
  end

  always_comb begin
    mul_a = r2;
    mul_b = r2;
    if (cmd.op == dfbs_pkg::OP_DOT_MUL) begin
      mul_a = signed'({1'b0, e_store[bi]});
      mul_b = signed'({1'b0, recip});
    end else begin
      case (cmd.step)
        4'd2: begin
          mul_a = r;
          mul_b = r;
        end
        4'd3: begin
          mul_a = r2;
          mul_b = r;
        end
        4'd5: begin
          mul_b = 16'sd16384;
        end
        4'd6: begin
          mul_a = r3;
          mul_b = 16'sd5461;
        end
        4'd7: begin
          mul_a = r4;
          mul_b = 16'sd1365;
        end
        default: begin
          mul_a = r2;
          mul_b = r2;
        end
      endcase
    end
    mq = mul_q15(mul_a, mul_b);
  end

  always_comb begin
    sum_hi = sum[SUM_W-1:4];
    reduced = (sum > SUM_W'(16)) ? 17'(sum_hi) : 17'd1;
    trial = {rem, 1'b0};
    if (anchor_r < 14'd6400) begin
      grid_pos_new = anchor_r;
      xg = 12'(grid_pos_new >> 4);
    end else if (anchor_r < 14'd8000) begin
      grid_pos_new = anchor_r - 14'd6400;
      xg = 12'(grid_pos_new >> 3);
    end else begin
      grid_pos_new = anchor_r - 14'd8000;
      xg = 12'(grid_pos_new >> 2);
    end
    gprod = 28'(xg) * 28'd52429;
    case (sel)
      2'd0: cols = 7'd80;
      2'd1: cols = 7'd40;
      default: cols = 7'd20;
    endcase
    gx_full = grid_pos - (14'(gy) * 14'(cols));
    ev = 27'(edges[cmd.step[1:0]]) << sh;
    case (cmd.step[1:0])
      2'd0: box_val = cx - ev;
      2'd1: box_val = cy - ev;
      2'd2: box_val = cx + ev;
      default: box_val = cy + ev;
    endcase
    sround = 31'(sprod) + 31'd16384;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dfbs_pkg::OP_LOAD_BIN: begin
        bin_store[bi] <= logit;
        anchor_r <= anchor_index;
      end
      dfbs_pkg::OP_LOAD_CLS: begin
        logit_r <= logit;
      end
      dfbs_pkg::OP_MAX: begin
        sum <= '0;
        if (bi == '0 || bin_store[bi] > mx) begin
          mx <= bin_store[bi];
        end
      end
      dfbs_pkg::OP_EXP: begin
        case (cmd.step)
          4'd0: begin
            z <= z_new;
            q <= qprod[20:16];
          end
          4'd1: r <= {rdiff[8:0], 7'd0};
          4'd2: r2 <= mq;
          4'd3: r3 <= mq;
          4'd4: r4 <= mq;
          4'd5: t2 <= mq;
          4'd6: t3 <= mq;
          4'd7: t4 <= mq;
          default: begin
            e <= e_new;
            if (!cmd.sig) begin
              e_store[bi] <= e_new;
              sum <= sum + SUM_W'(e_new);
            end
          end
        endcase
      end
      dfbs_pkg::OP_DIV: begin
        if (cmd.step == 4'd0) begin
          dot <= '0;
          quot <= 15'd0;
          if (cmd.sig) begin
            divisor <= 17'd32768 + 17'(e);
            rem <= 17'd32768;
            sat <= (e == 15'd0);
          end else begin
            divisor <= reduced;
            rem <= 17'd2048;
            sat <= (reduced <= 17'd2048);
          end
        end else if (trial >= 18'(divisor)) begin
          rem <= 17'(trial - 18'(divisor));
          quot <= {quot[13:0], 1'b1};
        end else begin
          rem <= trial[16:0];
          quot <= {quot[13:0], 1'b0};
        end
      end
      dfbs_pkg::OP_DOT_MUL: begin
        m <= mq[14:0];
      end
      dfbs_pkg::OP_DOT_ACC: begin
        dot <= dot + EXP_W'(20'(bi) * 20'(m));
      end
      dfbs_pkg::OP_SAVE: begin
        edges[cmd.grp] <= dot;
      end
      dfbs_pkg::OP_GEO: begin
        if (cmd.step == 4'd0) begin
          grid_pos <= grid_pos_new;
          gy <= gprod[27:18];
          if (anchor_r < 14'd6400) begin
            sel <= 2'd0;
          end else if (anchor_r < 14'd8000) begin
            sel <= 2'd1;
          end else begin
            sel <= 2'd2;
          end
        end else begin
          sh <= 3'd3 + 3'(sel);
          cx <= 27'({gx_full[6:0], 1'b1}) << (5'd17 + 5'(sel));
          cy <= 27'({gy, 1'b1}) << (5'd17 + 5'(sel));
        end
      end
      dfbs_pkg::OP_SIG_MUL: begin
        sprod <= 30'(e) * 30'(recip);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dfbs_pkg::OP_BOX_OUT) begin
      value <= box_val;
      slot <= 7'(cmd.step[1:0]);
      last <= 1'b0;
    end else if (cmd.op == dfbs_pkg::OP_SIG_OUT) begin
      value <= logit_r[7] ? 27'(sround[30:15]) : 27'(recip);
      slot <= 7'(cmd.cls + 8'd4);
      last <= cmd.cls_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == dfbs_pkg::OP_BOX_OUT || cmd.op == dfbs_pkg::OP_SIG_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dfl_box_and_score_decode.sv =====
// Sequence: a plain bin byte is stored while the sequencer stays idle; a group's last bin byte
// starts a max scan over the BINS bins, a 9-step exp per bin on one Q15 multiplier, a 16-step
// divider and a multiply step and an accumulate step per bin; the last DFL byte adds the geometry
// steps and 4 box transfers. A class byte takes 9 exp steps, 16 divider steps, a multiply and output.
// One item is processed at a time; the output register frees the input side once loaded.
// Reset (synchronous, active high) returns to the start of a record with no result pending.
`default_nettype none
module dfl_box_and_score_decode #(
  parameter int BINS = 16,
  parameter int CLASS_COUNT = 80
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // logit [7:0], anchor_index [21:8], zero fill
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // value [26:0], zero fill
  output logic [6:0]       m_axis_tuser,   // slot [6:0]
  output logic             m_axis_tlast
);

  dfbs_pkg::cmd_t cmd;
  dfbs_pkg::status_t status;
  logic signed [26:0] value;

  dfbs_ctrl #(
    .BINS(BINS),
    .CLASS_COUNT(CLASS_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status(status),
    .cmd(cmd)
  );

  dfbs_dp #(
    .BINS(BINS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .logit(signed'(s_axis_tdata[7:0])),
    .anchor_index(s_axis_tdata[21:8]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .value(value),
    .slot(m_axis_tuser),
    .last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, value};

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dfbs_pkg::OP_BOX_OUT || cmd.op == dfbs_pkg::OP_SIG_OUT) |-> status.out_free)
    else $error("Result written while the output register still holds a transfer.");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 7'(CLASS_COUNT + 3)))
    else $error("Last flag on a result other than the final class score.");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dfbs_pkg::OP_LOAD_BIN || cmd.op == dfbs_pkg::OP_LOAD_CLS)
      |-> (s_axis_tvalid && s_axis_tready))
    else $error("Input load issued without an input transfer.");

endmodule
`default_nettype wire

// ===== tb/sv/dfl_box_and_score_decode_checker.sv =====
// Checker for the DFL box and score decoder: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module dfl_box_and_score_decode_checker #(
  parameter int BINS = 16,
  parameter int CLASS_COUNT = 80
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic [6:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               fail_count,
  output int               pending
);

  localparam int DFL_BYTES = 4 * BINS;
  localparam int RECORD_BYTES = DFL_BYTES + CLASS_COUNT;

  typedef struct packed {
    logic [26:0] value;
    logic [6:0]  slot;
    logic        last;
  } decode_result_t;

  decode_result_t score_queue[$];
  int             record_pos;
  int             bin_vals[BINS];
  int unsigned    edge_q15[4];

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int q15_mul(int a, int b);
    longint prod;
    longint rem;
    longint fl;
    prod = longint'(a) * longint'(b);
    rem = prod & 64'h7FFF;
    fl = (prod - rem) / 32768;
    if (rem > 16384 || (rem == 16384 && fl[0])) fl++;
    return sat16(fl);
  endfunction

  function automatic int exp_neg(int z);
    int zq8, q, r, r2, r3, r4, poly;
    if (z < 0) z = 0;
    zq8 = z * 16;
    q = zq8 / 177;
    r = (q * 177 - zq8) * 128;
    r2 = q15_mul(r, r);
    r3 = q15_mul(r2, r);
    r4 = q15_mul(r2, r2);
    poly = sat16(longint'(32767) + r + q15_mul(r2, 16384) + q15_mul(r3, 5461) +
                 q15_mul(r4, 1365));
    if (poly < 0) poly = 0;
    if (q >= 15) return 0;
    return poly >>> q;
  endfunction

  function automatic int unsigned bin_expectation();
    int e[BINS];
    int mx, sum, recip;
    int unsigned reduced, dot;
    mx = bin_vals[0];
    sum = 0;
    dot = 0;
    for (int i = 1; i < BINS; i++) if (bin_vals[i] > mx) mx = bin_vals[i];
    for (int i = 0; i < BINS; i++) begin
      e[i] = exp_neg(mx - bin_vals[i]);
      sum += e[i];
    end
    reduced = (sum > 16) ? (sum >> 4) : 1;
    recip = int'((32'd1 << 26) / reduced);
    if (recip > 32767) recip = 32767;
    for (int i = 0; i < BINS; i++) dot += i * q15_mul(e[i], recip);
    return dot;
  endfunction

  function automatic logic [26:0] sigmoid_score(int l);
    int m, e;
    int unsigned inv;
    m = (l < 0) ? -l : l;
    e = exp_neg(m);
    inv = (32'd1 << 30) / (32768 + e);
    if (inv > 32767) inv = 32767;
    if (l >= 0) return 27'(inv);
    return 27'((e * inv + 16384) >> 15);
  endfunction

  task automatic push_box(int unsigned anchor);
    longint stride, cols, grid_pos, cx, cy;
    decode_result_t r;
    longint pix[4];
    if (anchor < 6400) begin
      stride = 8; cols = 80; grid_pos = anchor;
    end else if (anchor < 8000) begin
      stride = 16; cols = 40; grid_pos = anchor - 6400;
    end else begin
      stride = 32; cols = 20; grid_pos = anchor - 8000;
    end
    cx = (2 * (grid_pos % cols) + 1) * stride * 16384;
    cy = (2 * (grid_pos / cols) + 1) * stride * 16384;
    pix[0] = cx - longint'(edge_q15[0]) * stride;
    pix[1] = cy - longint'(edge_q15[1]) * stride;
    pix[2] = cx + longint'(edge_q15[2]) * stride;
    pix[3] = cy + longint'(edge_q15[3]) * stride;
    for (int k = 0; k < 4; k++) begin
      r.value = pix[k][26:0];
      r.slot = 7'(k);
      r.last = 1'b0;
      score_queue.push_back(r);
    end
  endtask

  task automatic predict_byte(logic [7:0] raw, logic [13:0] anchor);
    int l, cls;
    decode_result_t r;
    l = int'($signed(raw));
    if (record_pos < DFL_BYTES) begin
      bin_vals[record_pos % BINS] = l;
      if (record_pos % BINS == BINS - 1)
        edge_q15[(record_pos / BINS) % 4] = bin_expectation();
      if (record_pos == DFL_BYTES - 1) push_box(anchor);
    end else begin
      cls = record_pos - DFL_BYTES;
      r.value = sigmoid_score(l);
      r.slot = 7'(4 + cls);
      r.last = (cls == CLASS_COUNT - 1);
      score_queue.push_back(r);
    end
    record_pos = (record_pos + 1 >= RECORD_BYTES) ? 0 : record_pos + 1;
  endtask

  always @(posedge clk) begin
    decode_result_t want;
    if (rst) begin
      record_pos = 0;
      fail_count = 0;
      score_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (score_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transfer: value %0h slot %0d last %0b",
                     m_axis_tdata[26:0], m_axis_tuser, m_axis_tlast);
        end else begin
          want = score_queue.pop_front();
          if (m_axis_tdata[26:0] !== want.value || m_axis_tuser !== want.slot ||
              m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected value %0h slot %0d last %0b, got %0h %0d %0b",
                       want.value, want.slot, want.last, m_axis_tdata[26:0],
                       m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_byte(s_axis_tdata[7:0], s_axis_tdata[21:8]);
    end
    pending = score_queue.size();
  end

endmodule

// ===== tb/sv/dfl_box_and_score_decode_test.sv =====
// Top of the DFL box and score decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module dfl_box_and_score_decode_test;

  localparam int BINS = 16;
  localparam int CLASS_COUNT = 80;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [6:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          sent;
  logic        hold_off;
  logic        start_hold;

  dfl_box_and_score_decode #(.BINS(BINS), .CLASS_COUNT(CLASS_COUNT)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  dfl_box_and_score_decode_checker #(.BINS(BINS), .CLASS_COUNT(CLASS_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("dfl_box_and_score_decode verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    hold_off = 1'b0;
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_byte(logic [7:0] logit, logic [13:0] anchor);
    if (sent == 48) begin
      send_idle_pct = 82;
      recv_idle_pct = 12;
    end else if (sent == 96) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      start_hold = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, anchor, logit};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [7:0] directed_bin(int grp, int i);
    case (grp)
      0: return 8'd0;
      1: return (i == 5) ? 8'sd127 : -8'sd128;
      2: return (i % 2) ? 8'sd127 : -8'sd128;
      default: return 8'(i * 16 - 128);
    endcase
  endfunction

  task automatic send_record(int rec, logic [13:0] box_anchor);
    logic [7:0] logit;
    int mode, peak;
    for (int g = 0; g < 4; g++) begin
      mode = $urandom_range(2);
      peak = $urandom_range(BINS - 1);
      for (int i = 0; i < BINS; i++) begin
        if (rec == 0) logit = directed_bin(g, i);
        else if (mode == 0) logit = 8'($urandom);
        else if (i == peak) logit = 8'($urandom_range(127, 40));
        else logit = 8'($urandom_range(40) - 80 + (mode == 2 ? 100 : 0));
        send_byte(logit, (g == 3 && i == BINS - 1) ? box_anchor : 14'($urandom));
      end
    end
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (rec == 0 && c < 6) begin
        case (c)
          0: logit = -8'sd128;
          1: logit = 8'sd127;
          2: logit = 8'd0;
          3: logit = -8'sd1;
          4: logit = 8'sd1;
          default: logit = 8'sd64;
        endcase
      end else begin
        logit = 8'($urandom);
      end
      send_byte(logit, 14'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    start_hold = 1'b0;
    sent = 0;
    send_idle_pct = 12;
    recv_idle_pct = 82;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_record(0, 14'd16383);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("dfl_box_and_score_decode verification clean");
    else
      $display("dfl_box_and_score_decode verification failed");
    $finish;
  end

endmodule
